// ===== sv/shab_pkg.sv =====
`timescale 1ns / 1ps

package shab_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } shab_state_t;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned DIGEST_WORDS = 8;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_SLOT = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [0:DIGEST_WORDS-1] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== sv/shab_if.sv =====
`timescale 1ns / 1ps

interface shab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input end_of_message, output ready);
endinterface

interface shab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;

  modport source (output valid, output digest_word, output word_index,
                  output final_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input final_word, output ready);
endinterface

// ===== sv/sha256_byte_hasher.sv =====
`timescale 1ns / 1ps

// Channel    Dir  Payload                                   Item
// in_chan    in   data_byte, byte_present, end_of_message   one message byte and/or end mark
// out_chan   out  digest_word, word_index, final_word       one digest word, H0 first
//
// A byte item is taken while the block is idle; the 64th byte of a block starts the
// compression, which runs one round per cycle on a single round unit, then folds the
// result into the chaining value, with in_chan.ready low throughout.
// An end mark feeds padding and length one byte per cycle through the same byte path
// and runs one or two compressions, then holds eight digest words for out_chan.
// No bytes are taken during a compression; a stalled out_chan holds the current word.
// Reset is synchronous and active low and leaves the initial hash vector loaded.

module sha256_byte_hasher (
  input logic       clk,
  input logic       rst_n,
  shab_in_if.sink   in_chan,
  shab_out_if.source out_chan
);
  import shab_pkg::*;

  shab_state_t state_r, state_nxt;

  logic [5:0]   rnd_r, rnd_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [60:0]  len_r, len_nxt;
  logic [511:0] blk_r, blk_nxt;
  logic [31:0]  chain_r [0:DIGEST_WORDS-1];
  logic [31:0]  chain_nxt [0:DIGEST_WORDS-1];
  logic [31:0]  wv_r [0:DIGEST_WORDS-1];
  logic [31:0]  wv_nxt [0:DIGEST_WORDS-1];
  logic         fin_r, fin_nxt;
  logic         mark_r, mark_nxt;
  logic         len_blk_r, len_blk_nxt;
  logic [2:0]   idx_r, idx_nxt;

  logic         in_acc, out_acc, full;
  logic         shift_en;
  logic [7:0]   shift_byte;
  logic [63:0]  len_bits_sh;
  logic [7:0]   len_byte;
  logic [31:0]  w_new, t1, t2, ch, maj;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;
  assign full    = (fill_r == LAST_SLOT);

  assign len_bits_sh = {len_r, 3'b000} << {fill_r[2:0], 3'b000};
  assign len_byte    = len_bits_sh[63:56];

  assign w_new = small_sigma1(blk_r[63:32]) + blk_r[223:192]
               + small_sigma0(blk_r[479:448]) + blk_r[511:480];

  assign ch  = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign maj = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t1  = wv_r[7] + big_sigma1(wv_r[4]) + ch + ROUND_K[rnd_r] + blk_r[511:480];
  assign t2  = big_sigma0(wv_r[0]) + maj;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.byte_present && full) begin
            state_nxt = ST_ROUND;
          end else if (in_chan.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_r == LAST_SLOT) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (len_blk_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (full) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_EMIT: begin
        if (out_acc && idx_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rnd_nxt     = rnd_r;
    fill_nxt    = fill_r;
    len_nxt     = len_r;
    blk_nxt     = blk_r;
    chain_nxt   = chain_r;
    wv_nxt      = wv_r;
    fin_nxt     = fin_r;
    mark_nxt    = mark_r;
    len_blk_nxt = len_blk_r;
    idx_nxt     = idx_r;
    shift_en    = 1'b0;
    shift_byte  = 8'h00;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_chan.byte_present) begin
          shift_en   = 1'b1;
          shift_byte = in_chan.data_byte;
          len_nxt    = len_r + 61'd1;
        end
        if (in_acc && in_chan.end_of_message) begin
          fin_nxt     = 1'b1;
          mark_nxt    = 1'b1;
          len_blk_nxt = 1'b0;
        end
      end
      ST_ROUND: begin
        blk_nxt   = {blk_r[479:0], w_new};
        wv_nxt[7] = wv_r[6];
        wv_nxt[6] = wv_r[5];
        wv_nxt[5] = wv_r[4];
        wv_nxt[4] = wv_r[3] + t1;
        wv_nxt[3] = wv_r[2];
        wv_nxt[2] = wv_r[1];
        wv_nxt[1] = wv_r[0];
        wv_nxt[0] = t1 + t2;
        rnd_nxt   = rnd_r + 6'd1;
      end
      ST_FOLD: begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain_nxt[i] = chain_r[i] + wv_r[i];
          wv_nxt[i]    = chain_r[i] + wv_r[i];
        end
        if (fin_r && !len_blk_r && !mark_r) begin
          len_blk_nxt = 1'b1;
        end
      end
      ST_PAD: begin
        shift_en = 1'b1;
        if (mark_r) begin
          shift_byte  = PAD_MARK;
          mark_nxt    = 1'b0;
          len_blk_nxt = (fill_r < LEN_START);
        end else if (len_blk_r && fill_r >= LEN_START) begin
          shift_byte = len_byte;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_WORD) begin
            chain_nxt   = INIT_H;
            wv_nxt      = INIT_H;
            len_nxt     = '0;
            fin_nxt     = 1'b0;
            len_blk_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    if (shift_en) begin
      blk_nxt  = {blk_r[503:0], shift_byte};
      fill_nxt = fill_r + 6'd1;
    end
  end

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = (state_r == ST_EMIT);
  assign out_chan.digest_word = chain_r[idx_r];
  assign out_chan.word_index  = idx_r;
  assign out_chan.final_word  = (idx_r == LAST_WORD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rnd_r     <= '0;
      fill_r    <= '0;
      len_r     <= '0;
      chain_r   <= INIT_H;
      wv_r      <= INIT_H;
      fin_r     <= 1'b0;
      mark_r    <= 1'b0;
      len_blk_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      rnd_r     <= rnd_nxt;
      fill_r    <= fill_nxt;
      len_r     <= len_nxt;
      chain_r   <= chain_nxt;
      wv_r      <= wv_nxt;
      fin_r     <= fin_nxt;
      mark_r    <= mark_nxt;
      len_blk_r <= len_blk_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

// ===== sv/shab_checker.sv =====
`timescale 1ns / 1ps

module shab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_final_word
);

  // Input is never taken while a digest is being delivered.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest words are pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("stalled digest word changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_word |=>
      out_valid && out_word_index == 3'($past(out_word_index) + 3'd1))
    else $error("digest words not delivered in order");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_final_word |=> !out_valid && in_ready)
    else $error("block did not return to idle after the last digest word");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_final_word == (out_word_index == 3'd7))
    else $error("final_word flag does not match word_index");

endmodule

bind sha256_byte_hasher shab_checker u_shab_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_digest_word (out_chan.digest_word),
  .out_word_index  (out_chan.word_index),
  .out_final_word  (out_chan.final_word)
);
